[rtl/core/aacrtp_pkg.sv]
// Shared types, constants and functions of the RTP AAC-hbr to ADTS converter.
package aacrtp_pkg;

   localparam int BYTE_W = 8;
   localparam int LEN_W = 16;
   localparam int SIZE_W = 13;
   localparam int HDR_CNT_W = 13;
   localparam int RATE_W = 17;
   localparam int MODE_W = 3;
   localparam int CHAN_W = 3;
   localparam int RIDX_W = 4;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 17;
   localparam int SEQ_W = 3;

   localparam logic [CSR_IDX_W-1:0] CSR_AAC_MODE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SAMPLE_RATE = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CHANNEL_COUNT = 2'd2;

   localparam logic [MODE_W-1:0] MODE_AAC_HBR = 3'd5;
   localparam logic [MODE_W-1:0] MODE_RESET = 3'd0;
   localparam logic [RATE_W-1:0] RATE_RESET = 17'd48000;
   localparam logic [CHAN_W-1:0] CHAN_RESET = 3'd2;

   localparam logic [BYTE_W-1:0] ADTS_SYNC_HI = 8'hff;
   localparam logic [BYTE_W-1:0] ADTS_SYNC_LO = 8'hf9;
   localparam logic [BYTE_W-1:0] ADTS_PROFILE_LC = 8'h40;
   localparam logic [4:0] ADTS_FULLNESS_HI = 5'h1f;
   localparam logic [BYTE_W-1:0] ADTS_FULLNESS_LO = 8'hfc;
   localparam logic [SIZE_W-1:0] ADTS_HDR_LEN = 13'd7;

   localparam logic [SEQ_W-1:0] SEQ_SYNC_HI = 3'd0;
   localparam logic [SEQ_W-1:0] SEQ_SYNC_LO = 3'd1;
   localparam logic [SEQ_W-1:0] SEQ_RATE = 3'd2;
   localparam logic [SEQ_W-1:0] SEQ_CHAN_LEN = 3'd3;
   localparam logic [SEQ_W-1:0] SEQ_LEN_MID = 3'd4;
   localparam logic [SEQ_W-1:0] SEQ_LEN_LO = 3'd5;
   localparam logic [SEQ_W-1:0] SEQ_FULLNESS = 3'd6;
   localparam logic [SEQ_W-1:0] SEQ_PAYLOAD = 3'd7;

   typedef enum logic [4:0] {
      PH_IDLE   = 5'b00001,
      PH_LEN_LO = 5'b00010,
      PH_HDR_HI = 5'b00100,
      PH_HDR_LO = 5'b01000,
      PH_DATA   = 5'b10000
   } phase_type;

   typedef struct packed {
      logic                valid;
      logic                header;
      logic [BYTE_W-1:0]   data;
      logic                frame_end;
      logic [SIZE_W-1:0]   frame_len;
   } event_type;

   function automatic logic [RIDX_W-1:0] rate_index(input logic [RATE_W-1:0] hz);
      logic [RIDX_W-1:0] idx;
      case (hz)
         17'd96000: idx = 4'd0;
         17'd88200: idx = 4'd1;
         17'd64000: idx = 4'd2;
         17'd48000: idx = 4'd3;
         17'd44100: idx = 4'd4;
         17'd32000: idx = 4'd5;
         17'd24000: idx = 4'd6;
         17'd22050: idx = 4'd7;
         17'd16000: idx = 4'd8;
         17'd12000: idx = 4'd9;
         17'd11025: idx = 4'd10;
         17'd8000:  idx = 4'd11;
         default:   idx = 4'd15;
      endcase
      return idx;
   endfunction

endpackage

[rtl/core/aacrtp_req_if.sv]
// Request channel carrying RTP payload bytes into the converter.
interface aacrtp_req_if;
   logic        valid;
   logic        ready;
   logic [7:0]  data_byte;
   logic        packet_start;
   logic [15:0] payload_length;

   modport source(output valid, data_byte, packet_start, payload_length, input ready);
   modport sink(input valid, data_byte, packet_start, payload_length, output ready);
endinterface

[rtl/core/aacrtp_rsp_if.sv]
// Result channel carrying ADTS stream bytes out of the converter.
interface aacrtp_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       frame_end;
   logic       last;

   modport source(output valid, out_byte, frame_end, last, input ready);
   modport sink(input valid, out_byte, frame_end, last, output ready);
endinterface

[rtl/core/aacrtp_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module aacrtp_ram #(
   parameter int WIDTH = 13,
   parameter int DEPTH = 64,
   parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/core/aacrtp_parse.sv]
// Payload parser: AU-header table in RAM, packet and AU byte accounting.
module aacrtp_parse
   import aacrtp_pkg::*;
#(
   parameter int MAX_AU = 64
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              accept,
   input  logic [BYTE_W-1:0] data_byte,
   input  logic              packet_start,
   input  logic [LEN_W-1:0]  payload_length,
   input  logic [MODE_W-1:0] aac_mode,
   output event_type         ev
);

   localparam int AW = (MAX_AU > 1) ? $clog2(MAX_AU) : 1;
   localparam int CW = $clog2(MAX_AU + 1);
   localparam logic [CW-1:0] AU_LIMIT = CW'(MAX_AU);

   phase_type            phase_ff, phase_in;
   logic [BYTE_W-1:0]    len_hi_ff, len_hi_in;
   logic [HDR_CNT_W-1:0] hdr_left_ff, hdr_left_in;
   logic [BYTE_W-1:0]    hdr_part_ff, hdr_part_in;
   logic [CW-1:0]        au_count_ff, au_count_in;
   logic [CW-1:0]        cur_au_ff, cur_au_in;
   logic [SIZE_W-1:0]    au_left_ff, au_left_in;
   logic [LEN_W-1:0]     pkt_left_ff, pkt_left_in;
   logic                 fwd_hit_ff, fwd_hit_in;
   logic [SIZE_W-1:0]    fwd_data_ff;

   logic                 wr_en;
   logic [SIZE_W-1:0]    wr_data;
   logic [SIZE_W-1:0]    rd_data;
   logic [SIZE_W-1:0]    au_size;
   logic [LEN_W-1:0]     len_bits;
   logic [HDR_CNT_W:0]   hdr_bytes;
   logic [SIZE_W-1:0]    au_left_dec;

   aacrtp_ram #(
      .WIDTH(SIZE_W),
      .DEPTH(MAX_AU),
      .AW   (AW)
   ) u_size_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(au_count_ff[AW-1:0]),
      .wr_data(wr_data),
      .rd_addr(cur_au_in[AW-1:0]),
      .rd_data(rd_data)
   );

   assign au_size = fwd_hit_ff ? fwd_data_ff : rd_data;
   assign len_bits = {len_hi_ff, data_byte};
   assign hdr_bytes = {1'b0, len_bits[LEN_W-1:3]} + {{HDR_CNT_W{1'b0}}, |len_bits[2:0]};
   assign wr_data = SIZE_W'({hdr_part_ff, data_byte} >> 3);
   assign fwd_hit_in = wr_en && (au_count_ff[AW-1:0] == cur_au_in[AW-1:0]);

   always_comb begin
      phase_in = phase_ff;
      len_hi_in = len_hi_ff;
      hdr_left_in = hdr_left_ff;
      hdr_part_in = hdr_part_ff;
      au_count_in = au_count_ff;
      cur_au_in = cur_au_ff;
      au_left_in = au_left_ff;
      pkt_left_in = pkt_left_ff;
      wr_en = 1'b0;
      au_left_dec = '0;
      ev = '0;
      if (accept) begin
         if (packet_start) begin
            au_count_in = '0;
            cur_au_in = '0;
            au_left_in = '0;
            if ((aac_mode != MODE_AAC_HBR) || (payload_length == '0)) begin
               phase_in = PH_IDLE;
               pkt_left_in = '0;
            end else begin
               len_hi_in = data_byte;
               pkt_left_in = payload_length - 16'd1;
               phase_in = PH_LEN_LO;
            end
         end else if (phase_ff != PH_IDLE) begin
            if (pkt_left_ff == '0) begin
               phase_in = PH_IDLE;
            end else begin
               pkt_left_in = pkt_left_ff - 16'd1;
               case (phase_ff)
                  PH_LEN_LO: begin
                     if (hdr_bytes == '0) begin
                        cur_au_in = '0;
                        au_left_in = '0;
                        phase_in = (au_count_ff != '0) ? PH_DATA : PH_IDLE;
                     end else begin
                        hdr_left_in = HDR_CNT_W'(hdr_bytes - 14'd1);
                        phase_in = PH_HDR_HI;
                     end
                  end
                  PH_HDR_HI, PH_HDR_LO: begin
                     if (phase_ff == PH_HDR_HI) begin
                        hdr_part_in = data_byte;
                        phase_in = PH_HDR_LO;
                     end else begin
                        if ((wr_data != '0) && (au_count_ff < AU_LIMIT)) begin
                           wr_en = 1'b1;
                           au_count_in = au_count_ff + 1'b1;
                        end
                        phase_in = PH_HDR_HI;
                     end
                     if (hdr_left_ff == '0) begin
                        cur_au_in = '0;
                        au_left_in = '0;
                        phase_in = (au_count_in != '0) ? PH_DATA : PH_IDLE;
                     end else begin
                        hdr_left_in = hdr_left_ff - 1'b1;
                     end
                  end
                  PH_DATA: begin
                     if (au_left_ff == '0) begin
                        if (cur_au_ff >= au_count_ff) begin
                           phase_in = PH_IDLE;
                        end else if ({{(LEN_W-SIZE_W){1'b0}}, au_size} > pkt_left_ff) begin
                           phase_in = PH_IDLE;
                        end else begin
                           cur_au_in = cur_au_ff + 1'b1;
                           au_left_dec = au_size - 1'b1;
                           au_left_in = au_left_dec;
                           ev.valid = 1'b1;
                           ev.header = 1'b1;
                           ev.data = data_byte;
                           ev.frame_end = (au_left_dec == '0);
                           ev.frame_len = au_size + ADTS_HDR_LEN;
                        end
                     end else begin
                        au_left_dec = au_left_ff - 1'b1;
                        au_left_in = au_left_dec;
                        ev.valid = 1'b1;
                        ev.data = data_byte;
                        ev.frame_end = (au_left_dec == '0);
                     end
                  end
                  default: begin
                     phase_in = PH_IDLE;
                  end
               endcase
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         len_hi_ff <= '0;
         hdr_left_ff <= '0;
         hdr_part_ff <= '0;
         au_count_ff <= '0;
         cur_au_ff <= '0;
         au_left_ff <= '0;
         pkt_left_ff <= '0;
         fwd_hit_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         len_hi_ff <= len_hi_in;
         hdr_left_ff <= hdr_left_in;
         hdr_part_ff <= hdr_part_in;
         au_count_ff <= au_count_in;
         cur_au_ff <= cur_au_in;
         au_left_ff <= au_left_in;
         pkt_left_ff <= pkt_left_in;
         fwd_hit_ff <= fwd_hit_in;
      end
   end

   always_ff @(posedge clock) begin
      fwd_data_ff <= wr_data;
   end

endmodule

[rtl/core/aacrtp_emit.sv]
// Output sequencer: ADTS header if any, then AU byte; one per ready cycle.
module aacrtp_emit
   import aacrtp_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  event_type         ev,
   output logic              ev_ready,
   input  logic [RIDX_W-1:0] rate_idx,
   input  logic [CHAN_W-1:0] channel,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [BYTE_W-1:0] rsp_byte,
   output logic              rsp_frame_end,
   output logic              rsp_last
);

   logic              busy_ff, busy_in;
   logic [SEQ_W-1:0]  seq_ff, seq_in;
   logic [BYTE_W-1:0] data_ff;
   logic              fe_ff;
   logic [SIZE_W-1:0] flen_ff;
   logic              take;
   logic              at_payload;

   assign at_payload = (seq_ff == SEQ_PAYLOAD);
   assign take = busy_ff && rsp_ready;
   assign ev_ready = !busy_ff || (take && at_payload);

   always_comb begin
      busy_in = busy_ff;
      seq_in = seq_ff;
      if (ev.valid) begin
         busy_in = 1'b1;
         seq_in = ev.header ? SEQ_SYNC_HI : SEQ_PAYLOAD;
      end else if (take) begin
         if (at_payload) begin
            busy_in = 1'b0;
         end else begin
            seq_in = seq_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         seq_ff <= SEQ_PAYLOAD;
      end else begin
         busy_ff <= busy_in;
         seq_ff <= seq_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ev.valid) begin
         data_ff <= ev.data;
         fe_ff <= ev.frame_end;
         flen_ff <= ev.frame_len;
      end
   end

   always_comb begin
      case (seq_ff)
         SEQ_SYNC_HI:  rsp_byte = ADTS_SYNC_HI;
         SEQ_SYNC_LO:  rsp_byte = ADTS_SYNC_LO;
         SEQ_RATE:     rsp_byte = ADTS_PROFILE_LC | {2'b00, rate_idx, 1'b0, channel[2]};
         SEQ_CHAN_LEN: rsp_byte = {channel[1:0], 4'b0000, flen_ff[12:11]};
         SEQ_LEN_MID:  rsp_byte = flen_ff[10:3];
         SEQ_LEN_LO:   rsp_byte = {flen_ff[2:0], ADTS_FULLNESS_HI};
         SEQ_FULLNESS: rsp_byte = ADTS_FULLNESS_LO;
         SEQ_PAYLOAD:  rsp_byte = data_ff;
         default:      rsp_byte = data_ff;
      endcase
   end

   assign rsp_valid = busy_ff;
   assign rsp_last = at_payload;
   assign rsp_frame_end = at_payload && fe_ff;

endmodule

[rtl/core/aac_hbr_rtp_to_adts.sv]
// Top level of the RTP AAC-hbr payload to ADTS stream converter.
//
// The request channel takes one RTP payload byte per request; packet_start
// marks the first byte and carries payload_length. The response channel
// returns the ADTS stream: for the first byte of each access unit a seven
// byte ADTS header followed by that byte, for every later AU byte the byte
// alone. Pass-through bytes flow at one request per cycle while the
// receiver is ready, each response appearing in the cycle after its request
// is accepted. A request that opens an access unit gives eight responses,
// so the request channel stalls while the header goes out.
// AU sizes are kept in a one-port-write RAM of MAX_AU entries, read at the
// next AU index ahead of use, with forwarding of a same-cycle write.
// The csr port writes aac_mode, sample_rate_hz and channel_count; write them
// only while no request is in flight.
// Reset returns the parser to waiting for a packet start, drops any pending
// response and restores the register defaults; no RAM clearing is needed.
// When the receiver stalls, the pending response holds and the request
// channel stalls once the single output stage is occupied.
module aac_hbr_rtp_to_adts
   import aacrtp_pkg::*;
#(
   parameter int MAX_AU = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   aacrtp_req_if.sink            req_ch,
   aacrtp_rsp_if.source          rsp_ch,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wr_data
);

   logic [MODE_W-1:0] aac_mode_ff;
   logic [RATE_W-1:0] sample_rate_ff;
   logic [CHAN_W-1:0] channel_count_ff;
   logic              req_accept;
   logic              ev_ready;
   event_type         ev;

   always_ff @(posedge clock) begin
      if (reset) begin
         aac_mode_ff <= MODE_RESET;
         sample_rate_ff <= RATE_RESET;
         channel_count_ff <= CHAN_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_AAC_MODE:      aac_mode_ff <= csr_wr_data[MODE_W-1:0];
            CSR_SAMPLE_RATE:   sample_rate_ff <= csr_wr_data[RATE_W-1:0];
            CSR_CHANNEL_COUNT: channel_count_ff <= csr_wr_data[CHAN_W-1:0];
            default: begin
            end
         endcase
      end
   end

   assign req_ch.ready = ev_ready;
   assign req_accept = req_ch.valid && ev_ready;

   aacrtp_parse #(
      .MAX_AU(MAX_AU)
   ) u_parse (
      .clock         (clock),
      .reset         (reset),
      .accept        (req_accept),
      .data_byte     (req_ch.data_byte),
      .packet_start  (req_ch.packet_start),
      .payload_length(req_ch.payload_length),
      .aac_mode      (aac_mode_ff),
      .ev            (ev)
   );

   aacrtp_emit u_emit (
      .clock        (clock),
      .reset        (reset),
      .ev           (ev),
      .ev_ready     (ev_ready),
      .rate_idx     (rate_index(sample_rate_ff)),
      .channel      (channel_count_ff),
      .rsp_valid    (rsp_ch.valid),
      .rsp_ready    (rsp_ch.ready),
      .rsp_byte     (rsp_ch.out_byte),
      .rsp_frame_end(rsp_ch.frame_end),
      .rsp_last     (rsp_ch.last)
   );

   a_header_stalls_req: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && !rsp_ch.last |-> !req_ch.ready)
      else $error("request accepted while an ADTS header is in progress");

   a_frame_end_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.frame_end |-> rsp_ch.last)
      else $error("frame end on a header byte");

   a_reset_clears_rsp: assert property (@(posedge clock)
      reset |=> !rsp_ch.valid)
      else $error("response pending after reset");

endmodule

[verif/tb.sv]
// Testbench for the RTP AAC-hbr to ADTS converter: directed table, random packets, byte checks.
`timescale 1ns / 100ps

module tb;
   import aacrtp_pkg::*;

   localparam int CAPACITY = 64;
   localparam int SETTLE_CYCLES = 16;
   localparam int TIMEOUT_NS = 3_000_000;
   localparam int HBR_BUDGET = 24;
   localparam int OTHER_BUDGET = 14;
   localparam logic [MODE_W-1:0] MODE_CELP_VBR = 3'd3;
   localparam int unsigned ADTS_RATES [12] = '{96000, 88200, 64000, 48000, 44100, 32000,
                                              24000, 22050, 16000, 12000, 11025, 8000};

   typedef enum logic {STEP_REQUEST, STEP_CSR} step_kind_type;

   typedef struct packed {
      step_kind_type             kind;
      logic                      packet_start;
      logic [BYTE_W-1:0]         data_byte;
      logic [LEN_W-1:0]          payload_length;
      logic [CSR_IDX_W-1:0]      csr_idx;
      logic [CSR_DATA_W-1:0]     csr_value;
      int                        n_out;
      logic [BYTE_W-1:0]         first_out;
   } directed_step_type;

   typedef struct packed {
      logic [BYTE_W-1:0] out_byte;
      logic              frame_end;
      logic              last;
   } adts_byte_type;

   localparam directed_step_type DIRECTED_STEPS [30] = '{
      '{STEP_REQUEST, 1'b1, 8'h00, 16'd3, CSR_AAC_MODE, 17'd0, 0, 8'h00},
      '{STEP_REQUEST, 1'b0, 8'h10, 16'd0, CSR_AAC_MODE, 17'd0, 0, 8'h00},
      '{STEP_CSR, 1'b0, 8'h00, 16'd0, CSR_AAC_MODE, 17'(MODE_AAC_HBR), 0, 8'h00},
      '{STEP_CSR, 1'b0, 8'h00, 16'd0, CSR_SAMPLE_RATE, 17'd96000, 0, 8'h00},
      '{STEP_CSR, 1'b0, 8'h00, 16'd0, CSR_CHANNEL_COUNT, 17'd0, 0, 8'h00},
      '{STEP_REQUEST, 1'b1, 8'h00, 16'd8, CSR_AAC_MODE, 17'd0, 0, 8'h00},
      '{STEP_REQUEST, 1'b0, 8'h18, 16'hffff, CSR_AAC_MODE, 17'd0, 0, 8'h00},
      '{STEP_REQUEST, 1'b0, 8'h00, 16'd0, CSR_AAC_MODE, 17'd0, 0, 8'h00},
      '{STEP_REQUEST, 1'b0, 8'h10, 16'd0, CSR_AAC_MODE, 17'd0, 0, 8'h00},
      '{STEP_REQUEST, 1'b0, 8'h5a, 16'd0, CSR_AAC_MODE, 17'd0, 0, 8'h00},
      '{STEP_REQUEST, 1'b0, 8'hff, 16'd0, CSR_AAC_MODE, 17'd0, 8, 8'hff},
      '{STEP_REQUEST, 1'b0, 8'h00, 16'd0, CSR_AAC_MODE, 17'd0, 1, 8'h00},
      '{STEP_REQUEST, 1'b0, 8'h77, 16'd0, CSR_AAC_MODE, 17'd0, 0, 8'h00},
      '{STEP_CSR, 1'b0, 8'h00, 16'd0, CSR_SAMPLE_RATE, 17'd12000, 0, 8'h00},
      '{STEP_CSR, 1'b0, 8'h00, 16'd0, CSR_CHANNEL_COUNT, 17'd7, 0, 8'h00},
      '{STEP_REQUEST, 1'b1, 8'hff, 16'd0, CSR_AAC_MODE, 17'd0, 0, 8'h00},
      '{STEP_REQUEST, 1'b1, 8'h00, 16'hffff, CSR_AAC_MODE, 17'd0, 0, 8'h00},
      '{STEP_REQUEST, 1'b0, 8'h20, 16'd0, CSR_AAC_MODE, 17'd0, 0, 8'h00},
      '{STEP_REQUEST, 1'b0, 8'h00, 16'd0, CSR_AAC_MODE, 17'd0, 0, 8'h00},
      '{STEP_REQUEST, 1'b0, 8'h00, 16'd0, CSR_AAC_MODE, 17'd0, 0, 8'h00},
      '{STEP_REQUEST, 1'b0, 8'hff, 16'd0, CSR_AAC_MODE, 17'd0, 0, 8'h00},
      '{STEP_REQUEST, 1'b0, 8'hf8, 16'd0, CSR_AAC_MODE, 17'd0, 0, 8'h00},
      '{STEP_REQUEST, 1'b0, 8'h12, 16'd0, CSR_AAC_MODE, 17'd0, 8, 8'hff},
      '{STEP_REQUEST, 1'b0, 8'h34, 16'd0, CSR_AAC_MODE, 17'd0, 1, 8'h34},
      '{STEP_REQUEST, 1'b1, 8'h00, 16'd6, CSR_AAC_MODE, 17'd0, 0, 8'h00},
      '{STEP_REQUEST, 1'b0, 8'h10, 16'd0, CSR_AAC_MODE, 17'd0, 0, 8'h00},
      '{STEP_REQUEST, 1'b0, 8'h00, 16'd0, CSR_AAC_MODE, 17'd0, 0, 8'h00},
      '{STEP_REQUEST, 1'b0, 8'h28, 16'd0, CSR_AAC_MODE, 17'd0, 0, 8'h00},
      '{STEP_REQUEST, 1'b0, 8'h99, 16'd0, CSR_AAC_MODE, 17'd0, 0, 8'h00},
      '{STEP_REQUEST, 1'b0, 8'h42, 16'd0, CSR_AAC_MODE, 17'd0, 0, 8'h00}
   };

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  csr_wr_en;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wr_data;

   aacrtp_req_if req_ch();
   aacrtp_rsp_if rsp_ch();

   aac_hbr_rtp_to_adts #(.MAX_AU(CAPACITY)) dut (
      .clock(clock),
      .reset(reset),
      .req_ch(req_ch),
      .rsp_ch(rsp_ch),
      .csr_wr_en(csr_wr_en),
      .csr_index(csr_index),
      .csr_wr_data(csr_wr_data)
   );

   logic [MODE_W-1:0] cfg_mode = MODE_RESET;
   logic [RATE_W-1:0] cfg_rate = RATE_RESET;
   logic [CHAN_W-1:0] cfg_chan = CHAN_RESET;

   phase_type         parse_phase = PH_IDLE;
   logic [7:0]        len_hi = '0;
   logic [12:0]       hdr_left = '0;
   logic [7:0]        hdr_partial = '0;
   logic [12:0]       au_sizes [CAPACITY];
   logic [6:0]        au_count = '0;
   logic [6:0]        au_index = '0;
   logic [12:0]       au_left = '0;
   logic [15:0]       pkt_left = '0;

   adts_byte_type     adts_bytes_due [$];
   int                burst_len;
   logic [7:0]        burst_lead;
   int unsigned       fail_count = 0;
   int unsigned       sent_count = 0;
   int unsigned       cycle_count = 0;
   int                rsp_hold = 0;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic logic [3:0] adts_rate_code(input logic [RATE_W-1:0] hz);
      for (int i = 0; i < 12; i++) begin
         if (ADTS_RATES[i] == hz) begin
            return 4'(i);
         end
      end
      return 4'd15;
   endfunction

   function automatic int pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if ((cycle_count % 640) < 120 || r < 70) begin
         return 0;
      end else if (r < 93) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(6, 20);
   endfunction

   task automatic open_access_units();
      au_index = '0;
      au_left = '0;
      parse_phase = (au_count != 0) ? PH_DATA : PH_IDLE;
   endtask

   task automatic convert_rtp_byte(input logic start, input logic [7:0] data,
                                   input logic [15:0] plen);
      adts_byte_type burst [$];
      int unsigned   remaining;
      int unsigned   bits;
      int unsigned   hb;
      int unsigned   size;
      logic [12:0]   flen;
      logic [3:0]    ridx;
      if (start) begin
         au_count = '0;
         au_index = '0;
         au_left = '0;
         if (cfg_mode != MODE_AAC_HBR || plen == 0) begin
            parse_phase = PH_IDLE;
            pkt_left = '0;
         end else begin
            len_hi = data;
            pkt_left = plen - 16'd1;
            parse_phase = PH_LEN_LO;
         end
      end else if (parse_phase != PH_IDLE) begin
         if (pkt_left == 0) begin
            parse_phase = PH_IDLE;
         end else begin
            remaining = pkt_left;
            pkt_left = pkt_left - 16'd1;
            case (parse_phase)
               PH_LEN_LO: begin
                  bits = {len_hi, data};
                  hb = (bits + 7) >> 3;
                  if (hb == 0) begin
                     open_access_units();
                  end else begin
                     hdr_left = 13'(hb - 1);
                     parse_phase = PH_HDR_HI;
                  end
               end
               PH_HDR_HI, PH_HDR_LO: begin
                  if (parse_phase == PH_HDR_HI) begin
                     hdr_partial = data;
                     parse_phase = PH_HDR_LO;
                  end else begin
                     size = {hdr_partial, data} >> 3;
                     if (size != 0 && au_count < CAPACITY) begin
                        au_sizes[au_count] = 13'(size);
                        au_count = au_count + 7'd1;
                     end
                     parse_phase = PH_HDR_HI;
                  end
                  if (hdr_left == 0) begin
                     open_access_units();
                  end else begin
                     hdr_left = hdr_left - 13'd1;
                  end
               end
               PH_DATA: begin
                  if (au_left == 0) begin
                     if (au_index >= au_count || au_sizes[au_index] > remaining) begin
                        parse_phase = PH_IDLE;
                     end else begin
                        size = au_sizes[au_index];
                        au_index = au_index + 7'd1;
                        flen = 13'(size + 7);
                        ridx = adts_rate_code(cfg_rate);
                        burst.push_back('{ADTS_SYNC_HI, 1'b0, 1'b0});
                        burst.push_back('{ADTS_SYNC_LO, 1'b0, 1'b0});
                        burst.push_back('{ADTS_PROFILE_LC | {2'b00, ridx, 1'b0, cfg_chan[2]},
                                          1'b0, 1'b0});
                        burst.push_back('{{cfg_chan[1:0], 4'b0000, flen[12:11]}, 1'b0, 1'b0});
                        burst.push_back('{flen[10:3], 1'b0, 1'b0});
                        burst.push_back('{{flen[2:0], ADTS_FULLNESS_HI}, 1'b0, 1'b0});
                        burst.push_back('{ADTS_FULLNESS_LO, 1'b0, 1'b0});
                        au_left = 13'(size);
                     end
                  end
                  if (parse_phase == PH_DATA) begin
                     au_left = au_left - 13'd1;
                     burst.push_back('{data, au_left == 0, 1'b0});
                  end
               end
               default: parse_phase = PH_IDLE;
            endcase
         end
      end
      burst_len = burst.size();
      burst_lead = 8'h00;
      if (burst.size() != 0) begin
         burst[burst.size() - 1].last = 1'b1;
         burst_lead = burst[0].out_byte;
         foreach (burst[i]) begin
            adts_bytes_due.push_back(burst[i]);
         end
      end
   endtask

   task automatic send_rtp_byte(input logic start, input logic [7:0] data,
                                input logic [15:0] plen);
      int gap;
      gap = pick_gap();
      @(negedge clock);
      if (gap > 0) begin
         req_ch.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_ch.valid = 1'b1;
      req_ch.packet_start = start;
      req_ch.data_byte = data;
      req_ch.payload_length = plen;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      convert_rtp_byte(start, data, plen);
      sent_count++;
   endtask

   task automatic settle_outputs();
      @(negedge clock);
      req_ch.valid = 1'b0;
      while (adts_bytes_due.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_register(input logic [CSR_IDX_W-1:0] idx,
                                 input logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_wr_en = 1'b1;
      csr_index = idx;
      csr_wr_data = value;
      @(negedge clock);
      csr_wr_en = 1'b0;
      case (idx)
         CSR_AAC_MODE: cfg_mode = value[MODE_W-1:0];
         CSR_SAMPLE_RATE: cfg_rate = value;
         CSR_CHANNEL_COUNT: cfg_chan = value[CHAN_W-1:0];
         default: ;
      endcase
   endtask

   task automatic append_packet(input int min_au, input int max_au, input int max_size,
                                input bit intact);
      logic [7:0]  body [$];
      int unsigned sizes [$];
      int unsigned n_au;
      int unsigned bits;
      int unsigned size;
      int unsigned total;
      int unsigned plen;
      int unsigned sent;
      int unsigned pick;
      bit          odd;
      n_au = $urandom_range(min_au, max_au);
      if (!intact && $urandom_range(0, 24) == 0) begin
         n_au = 0;
      end
      odd = intact ? 1'b0 : ($urandom_range(0, 7) == 0);
      bits = n_au * 16 + (odd ? 8 : 0);
      if (bits != 0) begin
         bits -= $urandom_range(0, 7);
      end
      body.push_back(bits[15:8]);
      body.push_back(bits[7:0]);
      for (int i = 0; i < n_au; i++) begin
         size = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, max_size);
         sizes.push_back(size);
         body.push_back(size[12:5]);
         body.push_back({size[4:0], 3'($urandom)});
      end
      if (odd) begin
         body.push_back(8'($urandom));
      end
      foreach (sizes[i]) begin
         repeat (sizes[i]) body.push_back(8'($urandom));
      end
      total = body.size();
      sent = total;
      plen = total;
      pick = intact ? 0 : $urandom_range(0, 99);
      if (pick < 70) begin
         sent = total + $urandom_range(0, 2);
      end else if (pick < 80) begin
         plen = $urandom_range(total, 65535);
      end else if (pick < 90) begin
         plen = $urandom_range(1, total);
      end else begin
         sent = $urandom_range(1, total);
      end
      while (body.size() < sent) body.push_back(8'($urandom));
      for (int i = 0; i < sent; i++) begin
         send_rtp_byte(i == 0, body[i], (i == 0) ? 16'(plen) : 16'($urandom));
      end
   endtask

   always @(negedge clock) begin
      if (rsp_hold != 0) begin
         rsp_ch.ready = 1'b0;
         rsp_hold--;
      end else begin
         rsp_ch.ready = 1'b1;
         rsp_hold = pick_gap();
      end
   end

   always @(posedge clock) begin
      adts_byte_type want;
      cycle_count <= cycle_count + 1;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (adts_bytes_due.size() == 0) begin
            $error("out_byte: expected nothing, got %02h", rsp_ch.out_byte);
            fail_count++;
         end else begin
            want = adts_bytes_due.pop_front();
            if (rsp_ch.out_byte !== want.out_byte) begin
               $error("out_byte: expected %02h, got %02h", want.out_byte, rsp_ch.out_byte);
               fail_count++;
            end
            if (rsp_ch.frame_end !== want.frame_end) begin
               $error("frame_end: expected %0b, got %0b", want.frame_end, rsp_ch.frame_end);
               fail_count++;
            end
            if (rsp_ch.last !== want.last) begin
               $error("last: expected %0b, got %0b", want.last, rsp_ch.last);
               fail_count++;
            end
         end
      end
   end

   initial begin
      #(TIMEOUT_NS);
      $display("Simulation FAILED");
      $finish;
   end

   initial begin
      int unsigned phase_base;
      int unsigned budget;
      int unsigned pick;
      reset = 1'b1;
      csr_wr_en = 1'b0;
      csr_index = '0;
      csr_wr_data = '0;
      req_ch.valid = 1'b0;
      req_ch.packet_start = 1'b0;
      req_ch.data_byte = '0;
      req_ch.payload_length = '0;
      rsp_ch.ready = 1'b0;
      repeat (10) @(negedge clock);
      reset = 1'b0;

      foreach (DIRECTED_STEPS[i]) begin
         if (DIRECTED_STEPS[i].kind == STEP_CSR) begin
            settle_outputs();
            write_register(DIRECTED_STEPS[i].csr_idx, DIRECTED_STEPS[i].csr_value);
         end else begin
            send_rtp_byte(DIRECTED_STEPS[i].packet_start, DIRECTED_STEPS[i].data_byte,
                          DIRECTED_STEPS[i].payload_length);
            if (burst_len != DIRECTED_STEPS[i].n_out ||
                (burst_len != 0 && burst_lead != DIRECTED_STEPS[i].first_out)) begin
               $error("request %0d: expected %0d bytes led by %02h, predicted %0d led by %02h",
                      i, DIRECTED_STEPS[i].n_out, DIRECTED_STEPS[i].first_out,
                      burst_len, burst_lead);
               fail_count++;
            end
         end
      end

      for (int p = 0; p < 6; p++) begin
         settle_outputs();
         write_register(CSR_AAC_MODE, (p == 3) ? 17'(MODE_CELP_VBR) : 17'(MODE_AAC_HBR));
         case (p)
            0: write_register(CSR_SAMPLE_RATE, 17'd8000);
            1: write_register(CSR_SAMPLE_RATE, 17'd0);
            4: write_register(CSR_SAMPLE_RATE, 17'($urandom_range(0, 96000)));
            default: write_register(CSR_SAMPLE_RATE, 17'(ADTS_RATES[$urandom_range(0, 11)]));
         endcase
         write_register(CSR_CHANNEL_COUNT,
                        (p == 0) ? 17'd7 : (p == 1) ? 17'd0 : 17'($urandom_range(0, 7)));
         budget = (p == 3) ? OTHER_BUDGET : HBR_BUDGET;
         phase_base = sent_count;
         while (sent_count - phase_base < budget) begin
            pick = $urandom_range(0, 99);
            if (pick < 80) begin
               append_packet(1, 4, 12, 1'b0);
            end else if (pick < 92) begin
               repeat ($urandom_range(1, 3)) send_rtp_byte(1'b0, 8'($urandom), 16'($urandom));
            end else begin
               send_rtp_byte(1'b1, 8'($urandom), 16'd0);
            end
         end
         if (p == 4) begin
            append_packet(80, 80, 1, 1'b1);
         end
      end

      settle_outputs();
      if (fail_count == 0 && adts_bytes_due.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
